[hdl/plsh_pkg.sv]
// Shared constants, types and fixed-point helpers of the Phong shading pipeline.
`default_nettype none

package plsh_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int DIFF_CUT  = ONE >> 10;
  localparam int OUT_MAX   = 131071;

  typedef enum logic [2:0] {
    CFG_LIGHT_DIR_X = 3'd0,
    CFG_LIGHT_DIR_Y = 3'd1,
    CFG_LIGHT_DIR_Z = 3'd2,
    CFG_LIGHT_RED   = 3'd3,
    CFG_LIGHT_GREEN = 3'd4,
    CFG_LIGHT_BLUE  = 3'd5
  } cfg_idx_e;

  // Values that ride alongside the specular power chain.
  typedef struct packed {
    logic [14:0] diff;
    logic [14:0] sscale;
    logic [16:0] lt_red;
    logic [16:0] lt_green;
    logic [16:0] lt_blue;
  } side_t;

  // Clamp a raw dot product (scale ONE*ONE) to a unit value in [0, ONE].
  function automatic logic [14:0] clamp_unit(input logic signed [41:0] raw);
    logic [27:0] q;
    q = raw[41:FRAC_BITS];
    if (raw <= 42'sd0) begin
      return 15'd0;
    end else if (q > 28'(ONE)) begin
      return 15'(ONE);
    end
    return q[14:0];
  endfunction

  // Fixed-point product of two non-negative 15-bit values whose result stays below 2^15.
  function automatic logic [14:0] umul_frac(input logic [14:0] a, input logic [14:0] b);
    logic [29:0] p;
    p = 30'(a) * 30'(b);
    return p[28:FRAC_BITS];
  endfunction

endpackage

`default_nettype wire

[hdl/phong_light_shade.sv]
// Top level: Phong diffuse and specular shading of one point under one directional light.
//
//  Channel   Ports                                        Direction  Beat
//  command   start, busy, normal/view/tint/scale inputs   in         start & !busy
//  result    done_o, shade_red/green/blue_o               out        done_o (one cycle)
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i/data   in         cfg_valid_i & cfg_ready_o
//
// A command beat is taken in every cycle; busy stays low and cfg_ready_o stays high.
// Each result passes through fifteen register stages after its command beat: dot products,
// reflection, the five-stage power chain, the color products and the output saturation.
// Reset clears the stage valid bits and loads the light registers with their defaults.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module phong_light_shade
  import plsh_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] normal_x_i,
  input  wire logic signed [15:0] normal_y_i,
  input  wire logic signed [15:0] normal_z_i,
  input  wire logic signed [15:0] view_x_i,
  input  wire logic signed [15:0] view_y_i,
  input  wire logic signed [15:0] view_z_i,
  input  wire logic        [14:0] tint_red_i,
  input  wire logic        [14:0] tint_green_i,
  input  wire logic        [14:0] tint_blue_i,
  input  wire logic        [14:0] specular_scale_i,
  input  wire logic        [14:0] diffuse_scale_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic        [2:0]  cfg_index_i,
  input  wire logic        [15:0] cfg_data_i,
  output logic                    done_o,
  output logic             [16:0] shade_red_o,
  output logic             [16:0] shade_green_o,
  output logic             [16:0] shade_blue_o
);

  // Configuration registers.
  logic signed [15:0] ldir_q [3];
  logic        [15:0] lcol_q [3];

  // Stage valid bits, front part (before the power chain) and back part.
  logic [5:0] vf_q;
  logic [3:0] vb_q;

  logic accept;
  assign accept      = start && !busy;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ldir_q[0] <= 16'sd0;
      ldir_q[1] <= -16'sd16384;
      ldir_q[2] <= 16'sd0;
      lcol_q[0] <= 16'(ONE);
      lcol_q[1] <= 16'(ONE);
      lcol_q[2] <= 16'(ONE);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LIGHT_DIR_X: ldir_q[0] <= cfg_data_i;
        CFG_LIGHT_DIR_Y: ldir_q[1] <= cfg_data_i;
        CFG_LIGHT_DIR_Z: ldir_q[2] <= cfg_data_i;
        CFG_LIGHT_RED:   lcol_q[0] <= cfg_data_i;
        CFG_LIGHT_GREEN: lcol_q[1] <= cfg_data_i;
        CFG_LIGHT_BLUE:  lcol_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: N.L products and light-times-tint products.
  logic signed [31:0] nlp_q [3];
  logic signed [15:0] n1_q [3];
  logic signed [15:0] v1_q [3];
  logic        [14:0] ds1_q, ss1_q;
  logic        [16:0] lt1_q [3];
  logic        [30:0] lt_prod [3];

  always_comb begin
    lt_prod[0] = 31'(lcol_q[0]) * 31'(tint_red_i);
    lt_prod[1] = 31'(lcol_q[1]) * 31'(tint_green_i);
    lt_prod[2] = 31'(lcol_q[2]) * 31'(tint_blue_i);
  end

  always_ff @(posedge clk_i) begin
    nlp_q[0] <= 32'(normal_x_i) * 32'(ldir_q[0]);
    nlp_q[1] <= 32'(normal_y_i) * 32'(ldir_q[1]);
    nlp_q[2] <= 32'(normal_z_i) * 32'(ldir_q[2]);
    n1_q[0]  <= normal_x_i;
    n1_q[1]  <= normal_y_i;
    n1_q[2]  <= normal_z_i;
    v1_q[0]  <= view_x_i;
    v1_q[1]  <= view_y_i;
    v1_q[2]  <= view_z_i;
    ds1_q    <= diffuse_scale_i;
    ss1_q    <= specular_scale_i;
    for (int i = 0; i < 3; i++) begin
      lt1_q[i] <= lt_prod[i][30:FRAC_BITS];
    end
  end

  // Stage 2: N.L sum, clamped diffuse dot and the floor-scaled N.L.
  logic signed [33:0] nl_raw_d;
  logic        [14:0] dclamp_q;
  logic signed [19:0] nl_q;
  logic signed [15:0] n2_q [3];
  logic signed [15:0] v2_q [3];
  logic        [14:0] ds2_q, ss2_q;
  logic        [16:0] lt2_q [3];

  assign nl_raw_d = 34'(nlp_q[0]) + 34'(nlp_q[1]) + 34'(nlp_q[2]);

  always_ff @(posedge clk_i) begin
    dclamp_q <= clamp_unit(-42'(nl_raw_d));
    nl_q     <= nl_raw_d[33:FRAC_BITS];
    n2_q     <= n1_q;
    v2_q     <= v1_q;
    ds2_q    <= ds1_q;
    ss2_q    <= ss1_q;
    lt2_q    <= lt1_q;
  end

  // Stage 3: diffuse term and the N.L * N products of the reflection.
  logic signed [35:0] t_q [3];
  logic        [14:0] diff3_q, ss3_q;
  logic signed [15:0] v3_q [3];
  logic        [16:0] lt3_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      t_q[i] <= 36'(nl_q) * 36'(n2_q[i]);
    end
    diff3_q <= umul_frac(dclamp_q, ds2_q);
    ss3_q   <= ss2_q;
    v3_q    <= v2_q;
    lt3_q   <= lt2_q;
  end

  // Stage 4: reflected direction R = L - 2 (N.L) N, floor-rounded.
  // Doubling before the floor shift equals shifting one place less.
  logic signed [23:0] r_q [3];
  logic        [14:0] diff4_q, ss4_q;
  logic signed [15:0] v4_q [3];
  logic        [16:0] lt4_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      r_q[i] <= 24'(ldir_q[i]) - 24'(t_q[i] >>> (FRAC_BITS - 1));
    end
    diff4_q <= diff3_q;
    ss4_q   <= ss3_q;
    v4_q    <= v3_q;
    lt4_q   <= lt3_q;
  end

  // Stage 5: R.V products.
  logic signed [39:0] rvp_q [3];
  logic        [14:0] diff5_q, ss5_q;
  logic        [16:0] lt5_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      rvp_q[i] <= 40'(r_q[i]) * 40'(v4_q[i]);
    end
    diff5_q <= diff4_q;
    ss5_q   <= ss4_q;
    lt5_q   <= lt4_q;
  end

  // Stage 6: clamped R.V.
  logic  [14:0] rv_q;
  side_t        side6_q;

  always_ff @(posedge clk_i) begin
    rv_q <= clamp_unit(42'(rvp_q[0]) + 42'(rvp_q[1]) + 42'(rvp_q[2]));
    side6_q.diff     <= diff5_q;
    side6_q.sscale   <= ss5_q;
    side6_q.lt_red   <= lt5_q[0];
    side6_q.lt_green <= lt5_q[1];
    side6_q.lt_blue  <= lt5_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else begin
      vf_q <= {vf_q[4:0], accept};
    end
  end

  // Stages 7 to 11: specular power.
  logic        pow_valid;
  logic [14:0] p20;
  side_t       side11;

  plsh_pow20 u_pow20 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vf_q[5]),
    .base_i  (rv_q),
    .side_i  (side6_q),
    .valid_o (pow_valid),
    .pow_o   (p20),
    .side_o  (side11)
  );

  // Stage 12: specular term.
  logic [14:0] spec12_q;
  side_t       side12_q;

  always_ff @(posedge clk_i) begin
    spec12_q <= umul_frac(p20, side11.sscale);
    side12_q <= side11;
  end

  // Stage 13: diffuse plus specular; specular is dropped under a faint diffuse.
  logic [15:0] sum13_q;
  logic [16:0] lt13_q [3];

  always_ff @(posedge clk_i) begin
    if (side12_q.diff < 15'(DIFF_CUT)) begin
      sum13_q <= 16'(side12_q.diff);
    end else begin
      sum13_q <= 16'(side12_q.diff) + 16'(spec12_q);
    end
    lt13_q[0] <= side12_q.lt_red;
    lt13_q[1] <= side12_q.lt_green;
    lt13_q[2] <= side12_q.lt_blue;
  end

  // Stage 14: color products.
  logic [18:0] c14_q [3];
  logic [32:0] c_prod [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_prod[i] = 33'(lt13_q[i]) * 33'(sum13_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      c14_q[i] <= c_prod[i][32:FRAC_BITS];
    end
  end

  // Stage 15: saturation into the output registers.
  logic [16:0] shade_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (c14_q[i] > 19'(OUT_MAX)) begin
        shade_q[i] <= 17'(OUT_MAX);
      end else begin
        shade_q[i] <= c14_q[i][16:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else begin
      vb_q <= {vb_q[2:0], pow_valid};
    end
  end

  assign done_o        = vb_q[3];
  assign shade_red_o   = shade_q[0];
  assign shade_green_o = shade_q[1];
  assign shade_blue_o  = shade_q[2];

endmodule

`default_nettype wire

[hdl/plsh_pow20.sv]
// Five-stage pipeline raising a unit value to the 20th power by repeated squaring.
`default_nettype none

module plsh_pow20
  import plsh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [14:0] base_i,
  input  wire side_t       side_i,
  output logic             valid_o,
  output logic [14:0]      pow_o,
  output side_t            side_o
);

  logic [4:0]  vld_q;
  logic [14:0] p2_q, p4_q, p8_q, p16_q, p20_q;
  logic [14:0] p4_d1_q, p4_d2_q;
  side_t       side_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q    <= umul_frac(base_i, base_i);
    p4_q    <= umul_frac(p2_q, p2_q);
    p8_q    <= umul_frac(p4_q, p4_q);
    p4_d1_q <= p4_q;
    p16_q   <= umul_frac(p8_q, p8_q);
    p4_d2_q <= p4_d1_q;
    p20_q   <= umul_frac(p16_q, p4_d2_q);
    side_q[0] <= side_i;
    for (int i = 1; i < 5; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  assign valid_o = vld_q[4];
  assign pow_o   = p20_q;
  assign side_o  = side_q[4];

endmodule

`default_nettype wire

[dv/tb_phong_light_shade.sv]
// Self-checking testbench for the Phong light shading pipeline.
module tb_phong_light_shade
  import plsh_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PIPE_DEPTH  = 15;

  typedef struct packed {
    logic signed [15:0] nx, ny, nz;
    logic signed [15:0] vx, vy, vz;
    logic [14:0]        tr, tg, tb;
    logic [14:0]        sw, dw;
  } pixel_t;

  typedef struct packed {
    logic [16:0] r, g, b;
  } shade_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [15:0] view_x = '0, view_y = '0, view_z = '0;
  logic        [14:0] tint_red = '0, tint_green = '0, tint_blue = '0;
  logic        [14:0] spec_scale = '0, diff_scale = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic        [2:0]  cfg_index = '0;
  logic        [15:0] cfg_data = '0;
  logic               done_o;
  logic        [16:0] shade_red_o, shade_green_o, shade_blue_o;

  // Shadow copy of the light registers, updated on each config beat.
  logic signed [15:0] dir_x = 16'sd0, dir_y = -16'sd16384, dir_z = 16'sd0;
  logic        [15:0] col_r = 16'd16384, col_g = 16'd16384, col_b = 16'd16384;

  shade_t      shade_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          burst_mode = 1'b0;

  phong_light_shade uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .normal_x_i      (normal_x),
    .normal_y_i      (normal_y),
    .normal_z_i      (normal_z),
    .view_x_i        (view_x),
    .view_y_i        (view_y),
    .view_z_i        (view_z),
    .tint_red_i      (tint_red),
    .tint_green_i    (tint_green),
    .tint_blue_i     (tint_blue),
    .specular_scale_i(spec_scale),
    .diffuse_scale_i (diff_scale),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .done_o          (done_o),
    .shade_red_o     (shade_red_o),
    .shade_green_o   (shade_green_o),
    .shade_blue_o    (shade_blue_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Fixed-point product, floor rounding.
  function automatic longint mulfx(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint clamp_dot(input longint raw);
    longint q;
    if (raw <= 0) return 0;
    q = raw >>> FRAC_BITS;
    return (q > ONE) ? longint'(ONE) : q;
  endfunction

  function automatic logic [16:0] tone(input logic [15:0] lc, input logic [14:0] tc,
                                       input longint sum);
    longint lt, c;
    lt = mulfx(longint'(lc), longint'(tc));
    c  = mulfx(lt, sum);
    if (c < 0) c = 0;
    if (c > OUT_MAX) c = OUT_MAX;
    return 17'(c);
  endfunction

  function automatic shade_t predict_shade(input pixel_t px);
    longint n[3], v[3], l[3], r[3];
    longint nl_raw, nl, rv_raw, rv, diff, spec, p2, p4, p8, p16, p20, sum;
    shade_t s;
    n[0] = longint'($signed(px.nx));
    n[1] = longint'($signed(px.ny));
    n[2] = longint'($signed(px.nz));
    v[0] = longint'($signed(px.vx));
    v[1] = longint'($signed(px.vy));
    v[2] = longint'($signed(px.vz));
    l[0] = longint'(dir_x);
    l[1] = longint'(dir_y);
    l[2] = longint'(dir_z);
    nl_raw = 0;
    for (int i = 0; i < 3; i++) nl_raw += n[i] * l[i];
    diff = mulfx(clamp_dot(-nl_raw), longint'(px.dw));
    // Reflected direction R = L - 2*dot(N,L)*N, each term floored.
    nl = nl_raw >>> FRAC_BITS;
    rv_raw = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = l[i] - ((2 * nl * n[i]) >>> FRAC_BITS);
      rv_raw += r[i] * v[i];
    end
    rv   = clamp_dot(rv_raw);
    p2   = mulfx(rv, rv);
    p4   = mulfx(p2, p2);
    p8   = mulfx(p4, p4);
    p16  = mulfx(p8, p8);
    p20  = mulfx(p16, p4);
    spec = mulfx(p20, longint'(px.sw));
    if (diff < DIFF_CUT) spec = 0;
    sum = diff + spec;
    s.r = tone(col_r, px.tr, sum);
    s.g = tone(col_g, px.tg, sum);
    s.b = tone(col_b, px.tb, sum);
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_shade
    shade_t want;
    if (rst_ni && done_o) begin
      if (shade_q.size() == 0) begin
        report_mismatch("result with none pending", 0, 1);
      end else begin
        want = shade_q.pop_front();
        if (shade_red_o !== want.r) report_mismatch("shade_red", want.r, shade_red_o);
        if (shade_green_o !== want.g) report_mismatch("shade_green", want.g, shade_green_o);
        if (shade_blue_o !== want.b) report_mismatch("shade_blue", want.b, shade_blue_o);
      end
    end
  end

  function automatic int unsigned next_gap();
    return burst_mode ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    gap = next_gap();
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start      = 1'b1;
    normal_x   = px.nx;
    normal_y   = px.ny;
    normal_z   = px.nz;
    view_x     = px.vx;
    view_y     = px.vy;
    view_z     = px.vz;
    tint_red   = px.tr;
    tint_green = px.tg;
    tint_blue  = px.tb;
    spec_scale = px.sw;
    diff_scale = px.dw;
    do @(posedge clk_i); while (busy);
    shade_q.insert(shade_q.size(), predict_shade(px));
  endtask

  // Stop issuing and wait until every pending result has come back.
  task automatic quiesce();
    @(negedge clk_i);
    start = 1'b0;
    while (shade_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    repeat ($urandom_range(0, 15)) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LIGHT_DIR_X: dir_x = val;
      CFG_LIGHT_DIR_Y: dir_y = val;
      CFG_LIGHT_DIR_Z: dir_z = val;
      CFG_LIGHT_RED:   col_r = val;
      CFG_LIGHT_GREEN: col_g = val;
      CFG_LIGHT_BLUE:  col_b = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic write_light(input logic [15:0] dx, dy, dz, cr, cg, cb);
    write_reg(CFG_LIGHT_DIR_X, dx);
    write_reg(CFG_LIGHT_DIR_Y, dy);
    write_reg(CFG_LIGHT_DIR_Z, dz);
    write_reg(CFG_LIGHT_RED, cr);
    write_reg(CFG_LIGHT_GREEN, cg);
    write_reg(CFG_LIGHT_BLUE, cb);
  endtask

  function automatic pixel_t mk_pixel(input int nx, ny, nz, vx, vy, vz,
                                      input int tr, tg, tb, sw, dw);
    pixel_t px;
    px.nx = 16'(nx); px.ny = 16'(ny); px.nz = 16'(nz);
    px.vx = 16'(vx); px.vy = 16'(vy); px.vz = 16'(vz);
    px.tr = 15'(tr); px.tg = 15'(tg); px.tb = 15'(tb);
    px.sw = 15'(sw); px.dw = 15'(dw);
    return px;
  endfunction

  task automatic rand_unit(output logic signed [15:0] x, y, z);
    real a, b, c, m;
    do begin
      a = real'(int'($urandom_range(0, 2000)) - 1000);
      b = real'(int'($urandom_range(0, 2000)) - 1000);
      c = real'(int'($urandom_range(0, 2000)) - 1000);
      m = $sqrt(a * a + b * b + c * c);
    end while (m < 1.0);
    x = 16'(int'(a / m * 16384.0));
    y = 16'(int'(b / m * 16384.0));
    z = 16'(int'(c / m * 16384.0));
  endtask

  function automatic logic [15:0] pick_extreme16();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'hC000;
      2:       return 16'h0000;
      3:       return 16'h4000;
      4:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] pick_extreme15();
    case ($urandom_range(0, 4))
      0:       return 15'd0;
      1:       return 15'd16384;
      2:       return 15'h7FFF;
      3:       return 15'd1;
      default: return 15'($urandom);
    endcase
  endfunction

  task automatic make_pixel(output pixel_t px);
    int unsigned kind;
    logic signed [15:0] x, y, z;
    real d, rx, ry, rz, m;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // Unit vectors, mostly lit, view often close to the mirror direction.
      rand_unit(x, y, z);
      if ((int'(x) * int'(dir_x) + int'(y) * int'(dir_y) + int'(z) * int'(dir_z) > 0) &&
          ($urandom_range(0, 7) != 0)) begin
        x = -x; y = -y; z = -z;
      end
      px.nx = x; px.ny = y; px.nz = z;
      if ($urandom_range(0, 2) != 0) begin
        d  = (real'(x) * real'(dir_x) + real'(y) * real'(dir_y) + real'(z) * real'(dir_z))
             / (16384.0 * 16384.0);
        rx = real'(dir_x) - 2.0 * d * real'(x) + real'(int'($urandom_range(0, 1600)) - 800);
        ry = real'(dir_y) - 2.0 * d * real'(y) + real'(int'($urandom_range(0, 1600)) - 800);
        rz = real'(dir_z) - 2.0 * d * real'(z) + real'(int'($urandom_range(0, 1600)) - 800);
        m  = $sqrt(rx * rx + ry * ry + rz * rz);
        if (m < 1.0) begin
          rand_unit(x, y, z);
        end else begin
          x = 16'(int'(rx / m * 16384.0));
          y = 16'(int'(ry / m * 16384.0));
          z = 16'(int'(rz / m * 16384.0));
        end
      end else begin
        rand_unit(x, y, z);
      end
      px.vx = x; px.vy = y; px.vz = z;
      px.tr = 15'($urandom_range(0, 16384));
      px.tg = 15'($urandom_range(0, 16384));
      px.tb = 15'($urandom_range(0, 16384));
      px.sw = 15'($urandom_range(0, 16384));
      px.dw = 15'($urandom_range(0, 16384));
    end else if (kind < 8) begin
      px.nx = pick_extreme16(); px.ny = pick_extreme16(); px.nz = pick_extreme16();
      px.vx = pick_extreme16(); px.vy = pick_extreme16(); px.vz = pick_extreme16();
      px.tr = pick_extreme15(); px.tg = pick_extreme15(); px.tb = pick_extreme15();
      px.sw = pick_extreme15(); px.dw = pick_extreme15();
    end else begin
      px.nx = 16'($urandom); px.ny = 16'($urandom); px.nz = 16'($urandom);
      px.vx = 16'($urandom); px.vy = 16'($urandom); px.vz = 16'($urandom);
      px.tr = 15'($urandom); px.tg = 15'($urandom); px.tb = 15'($urandom);
      px.sw = 15'($urandom); px.dw = 15'($urandom);
    end
  endtask

  // Light straight down the -y axis with the reset colors.
  task automatic test_default_light();
    send_pixel(mk_pixel(0, 16384, 0, 0, 16384, 0, 16384, 16384, 16384, 16384, 16384));
    send_pixel(mk_pixel(0, 16384, 0, 0, 16384, 0, 32767, 32767, 32767, 32767, 32767));
    send_pixel(mk_pixel(0, -16384, 0, 0, 16384, 0, 16384, 16384, 16384, 16384, 16384));
    send_pixel(mk_pixel(0, 32767, 0, 0, 32767, 0, 16384, 8192, 100, 16384, 16384));
    // Diffuse just under and exactly at the specular cut threshold.
    send_pixel(mk_pixel(0, 16384, 0, 0, 16384, 0, 16384, 16384, 16384, 16384, 15));
    send_pixel(mk_pixel(0, 16384, 0, 0, 16384, 0, 16384, 16384, 16384, 16384, 16));
    send_pixel(mk_pixel(-32768, -32768, -32768, 32767, 32767, 32767,
                        32767, 32767, 32767, 32767, 32767));
    send_pixel(mk_pixel(32767, 32767, 32767, -32768, -32768, -32768,
                        32767, 0, 16384, 32767, 32767));
    send_pixel(mk_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(0, 16384, 0, 16384, 0, 0, 16384, 16384, 16384, 16384, 16384));
    send_pixel(mk_pixel(0, 16384, 0, 0, -16384, 0, 16384, 16384, 16384, 16384, 16384));
    send_pixel(mk_pixel(11585, 11585, 0, 0, 16384, 0, 16384, 16384, 16384, 0, 16384));
    send_pixel(mk_pixel(0, 16384, 0, 0, 16384, 0, 0, 0, 0, 16384, 16384));
    quiesce();
  endtask

  task automatic test_light_registers();
    // Bright light; the first pixel drives every channel into saturation.
    write_light(16'h0000, 16'hC000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(mk_pixel(0, 16384, 0, 0, 16384, 0, 32767, 32767, 32767, 32767, 32767));
    send_pixel(mk_pixel(0, 16384, 0, 0, 16384, 0, 16384, 16384, 16384, 16384, 16384));
    send_pixel(mk_pixel(0, 16384, 0, 11585, 11585, 0, 16384, 1, 32767, 16384, 16384));
    quiesce();
    write_light(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'h4000);
    send_pixel(mk_pixel(32767, -32768, 32767, 32767, 32767, 32767,
                        32767, 32767, 32767, 32767, 32767));
    send_pixel(mk_pixel(16384, -16384, 16384, -16384, 16384, -16384,
                        16384, 16384, 16384, 16384, 16384));
    send_pixel(mk_pixel(-32768, 32767, -32768, 0, 0, 16384, 16384, 16384, 16384, 16384, 16384));
    quiesce();
    write_light(16'h7FFF, 16'h8000, 16'h7FFF, 16'h4000, 16'hFFFF, 16'h0000);
    send_pixel(mk_pixel(-32768, 32767, -32768, -32768, 32767, -32768,
                        32767, 32767, 32767, 32767, 32767));
    send_pixel(mk_pixel(-16384, 0, 0, 0, 0, 16384, 16384, 16384, 16384, 16384, 16384));
    quiesce();
  endtask

  task automatic test_random_phases();
    logic signed [15:0] x, y, z;
    pixel_t px;
    for (int phase = 0; phase < 5; phase++) begin
      rand_unit(x, y, z);
      case (phase)
        0: write_light(x, y, z, 16'd16384, 16'd16384, 16'd16384);
        1: write_light(x, y, z, 16'($urandom_range(0, 16384)),
                       16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384)));
        2: write_light(x, y, z, 16'($urandom), 16'($urandom), 16'($urandom));
        3: write_light(pick_extreme16(), pick_extreme16(), pick_extreme16(),
                       pick_extreme16(), pick_extreme16(), pick_extreme16());
        default: write_light(x, y, z, 16'($urandom_range(0, 32768)),
                             16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)));
      endcase
      for (int k = 0; k < 400; k++) begin
        if (k % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
        make_pixel(px);
        send_pixel(px);
      end
      quiesce();
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_default_light();
    test_light_registers();
    test_random_phases();

    quiesce();
    repeat (PIPE_DEPTH + 5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/plsh_pkg.sv
hdl/plsh_pow20.sv
hdl/phong_light_shade.sv
dv/tb_phong_light_shade.sv
